FILE: design/hcbd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hcbd_pkg: shared types and constants of the chunked body decoder
// Holds the phase encoding, the error codes, the state and result words and
// the hex digit decoder used by the per-byte step logic.
// ----------------------------------------------------------------------------
package hcbd_pkg;

  // Width of the chunk size counter.
  localparam int SizeBits = 32;

  // Framing characters.
  localparam logic [7:0] CharCr   = 8'h0D;
  localparam logic [7:0] CharLf   = 8'h0A;
  localparam logic [7:0] CharSemi = 8'h3B;

  // Progress of the CRLF / CRLFCRLF search.
  localparam logic [1:0] MatchNone  = 2'd0;
  localparam logic [1:0] MatchCr    = 2'd1;
  localparam logic [1:0] MatchCrLf  = 2'd2;
  localparam logic [1:0] MatchCrLfCr = 2'd3;

  // Decoder phases, one-hot.
  typedef enum logic [6:0] {
    PH_SIZE    = 7'b0000001,
    PH_EXT     = 7'b0000010,
    PH_DATA    = 7'b0000100,
    PH_DCR     = 7'b0001000,
    PH_DLF     = 7'b0010000,
    PH_TRAILER = 7'b0100000,
    PH_DONE    = 7'b1000000
  } phase_e;

  // Sticky error codes.
  typedef enum logic [2:0] {
    ERR_NONE       = 3'd0,
    ERR_NO_CRLF    = 3'd1,
    ERR_NO_DIGIT   = 3'd2,
    ERR_BAD_CHAR   = 3'd3,
    ERR_OVERFLOW   = 3'd4,
    ERR_AFTER_DONE = 3'd5
  } err_e;

  // Decoder state carried from one word to the next.
  typedef struct packed {
    phase_e              phase;
    logic [SizeBits-1:0] remaining;
    logic                digit_seen;
    logic [1:0]          match;
    err_e                err;
  } state_t;

  // Result fields of one word.
  typedef struct packed {
    logic       payload_valid;
    logic [7:0] payload_byte;
    logic       chunk_end;
    logic       body_done;
    logic [2:0] error_code;
  } result_t;

  // Hex digit decode: bit 4 flags a digit, bits 3:0 carry its value.
  function automatic logic [4:0] hex_decode(input logic [7:0] c);
    logic [4:0] r;
    r = 5'd0;
    if (c >= 8'h30 && c <= 8'h39) begin
      r = {1'b1, 4'(c - 8'h30)};
    end else if (c >= 8'h61 && c <= 8'h66) begin
      r = {1'b1, 4'(c - 8'h57)};
    end else if (c >= 8'h41 && c <= 8'h46) begin
      r = {1'b1, 4'(c - 8'h37)};
    end
    return r;
  endfunction

endpackage

FILE: design/http_chunked_body_decoder_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// http_chunked_body_decoder_core: HTTP/1.1 chunked transfer body decoder
// Takes one body byte per word and returns one result word per byte with the
// forwarded data byte, chunk and body end marks and a sticky error code.
// ----------------------------------------------------------------------------
//  Channel | Signals                                   | Direction
//  --------+-------------------------------------------+----------
//  in      | in_valid_i, in_ready_o, in_byte_i         | into block
//  out     | out_valid_o, out_ready_i, payload_valid_o,| out of block
//          | payload_byte_o, chunk_end_o, body_done_o, |
//          | error_code_o                              |
//
//  One word per cycle sustained while the output does not stall; the result
//  word passes through the input register, then the result register.
//  The decoder state is updated as a word moves from the input register into
//  the result register, so consecutive bytes follow back to back.
//  rst_ni clears the pipeline valids and the decoder state at once.
//  A stall on the output holds both registers; the input register frees as
//  soon as the result register can take its word.
// ----------------------------------------------------------------------------
module http_chunked_body_decoder_core (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] in_byte_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic       payload_valid_o,
  output logic [7:0] payload_byte_o,
  output logic       chunk_end_o,
  output logic       body_done_o,
  output logic [2:0] error_code_o
);
  import hcbd_pkg::*;

  logic       in_valid_q;
  logic [7:0] in_byte_q;
  logic       out_valid_q;
  result_t    res_q;
  result_t    res_d;
  state_t     st_q;
  state_t     st_d;
  logic       advance;

  // The result register can take a word when empty or being drained.
  assign advance    = !out_valid_q || out_ready_i;
  assign in_ready_o = !in_valid_q || advance;

  // Input register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      in_byte_q <= in_byte_i;
    end
  end

  // Per-byte decode.
  hcbd_step u_step (
    .state_i  (st_q),
    .byte_i   (in_byte_q),
    .state_o  (st_d),
    .result_o (res_d)
  );

  // Decoder state, committed when a word enters the result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q.phase      <= PH_SIZE;
      st_q.remaining  <= '0;
      st_q.digit_seen <= 1'b0;
      st_q.match      <= MatchNone;
      st_q.err        <= ERR_NONE;
    end else if (advance && in_valid_q) begin
      st_q <= st_d;
    end
  end

  // Result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= in_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && in_valid_q) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign payload_valid_o = res_q.payload_valid;
  assign payload_byte_o  = res_q.payload_byte;
  assign chunk_end_o     = res_q.chunk_end;
  assign body_done_o     = res_q.body_done;
  assign error_code_o    = res_q.error_code;

  // Errors never clear once raised.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q.err != ERR_NONE) |=> (st_q.err == $past(st_q.err)))
    else $error("sticky error changed");

  // A data word never carries an error code.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && payload_valid_o) |-> (error_code_o == ERR_NONE))
    else $error("data word flagged with error");

  // Chunk end only on a forwarded data byte.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && chunk_end_o) |-> payload_valid_o)
    else $error("chunk end without data");

  // Body done moves the decoder into the done phase.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (advance && in_valid_q && res_d.body_done) |=> (st_q.phase == PH_DONE))
    else $error("body done without done phase");

  // An empty result register always frees the input side.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> in_ready_o)
    else $error("input stalled with empty output");

endmodule

FILE: design/hcbd_step.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hcbd_step: per-byte next-state and result logic
// Purely combinational. Given the current decoder state and one body byte it
// returns the next state and the result word for that byte.
// ----------------------------------------------------------------------------
module hcbd_step (
  input  hcbd_pkg::state_t  state_i,
  input  logic [7:0]        byte_i,
  output hcbd_pkg::state_t  state_o,
  output hcbd_pkg::result_t result_o
);
  import hcbd_pkg::*;

  logic [4:0]          hex;
  logic                is_cr;
  logic                is_lf;
  logic                is_semi;
  logic [SizeBits-1:0] dec;
  err_e                err;
  state_t              nxt;
  result_t             res;

  assign hex     = hex_decode(byte_i);
  assign is_cr   = (byte_i == CharCr);
  assign is_lf   = (byte_i == CharLf);
  assign is_semi = (byte_i == CharSemi);
  assign dec     = state_i.remaining - SizeBits'(1);

  // Phase handling; an error freezes the state and blanks the result.
  always_comb begin
    nxt = state_i;
    res = '0;
    err = ERR_NONE;
    if (state_i.err != ERR_NONE) begin
      res.error_code = state_i.err;
    end else begin
      case (state_i.phase)
        PH_SIZE: begin
          if (hex[4]) begin
            if (|state_i.remaining[SizeBits-1 -: 4]) begin
              err = ERR_OVERFLOW;
            end else begin
              nxt.remaining  = {state_i.remaining[SizeBits-5:0], hex[3:0]};
              nxt.digit_seen = 1'b1;
            end
          end else if (!state_i.digit_seen) begin
            err = ERR_NO_DIGIT;
          end else if (is_cr || is_semi) begin
            nxt.match = is_cr ? MatchCr : MatchNone;
            nxt.phase = (state_i.remaining == '0) ? PH_TRAILER : PH_EXT;
          end else begin
            err = ERR_BAD_CHAR;
          end
        end
        PH_EXT: begin
          if (is_cr) begin
            nxt.match = MatchCr;
          end else if (is_lf && state_i.match == MatchCr) begin
            nxt.match      = MatchNone;
            nxt.digit_seen = 1'b0;
            nxt.phase      = PH_DATA;
          end else begin
            nxt.match = MatchNone;
          end
        end
        PH_DATA: begin
          res.payload_valid = 1'b1;
          res.payload_byte  = byte_i;
          nxt.remaining     = dec;
          if (dec == '0) begin
            res.chunk_end = 1'b1;
            nxt.phase     = PH_DCR;
          end
        end
        PH_DCR: begin
          if (is_cr) begin
            nxt.phase = PH_DLF;
          end else begin
            err = ERR_NO_CRLF;
          end
        end
        PH_DLF: begin
          if (is_lf) begin
            nxt.phase      = PH_SIZE;
            nxt.remaining  = '0;
            nxt.digit_seen = 1'b0;
          end else begin
            err = ERR_NO_CRLF;
          end
        end
        PH_TRAILER: begin
          if (is_cr) begin
            nxt.match = (state_i.match == MatchCrLf) ? MatchCrLfCr : MatchCr;
          end else if (is_lf && state_i.match == MatchCr) begin
            nxt.match = MatchCrLf;
          end else if (is_lf && state_i.match == MatchCrLfCr) begin
            nxt.match     = MatchNone;
            res.body_done = 1'b1;
            nxt.phase     = PH_DONE;
          end else begin
            nxt.match = MatchNone;
          end
        end
        default: begin
          err = ERR_AFTER_DONE;
        end
      endcase
      if (err != ERR_NONE) begin
        nxt            = state_i;
        nxt.err        = err;
        res            = '0;
        res.error_code = err;
      end
    end
  end

  assign state_o  = nxt;
  assign result_o = res;

endmodule

FILE: dv/http_chunked_body_decoder_core_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// http_chunked_body_decoder_core_tb: self-checking bench for the chunk decoder
// Feeds a chunked body, one byte per word. A directed part comes first, then
// many well-formed chunks with random sizes, extensions and data. The body
// ends in one randomly chosen way: a normal trailer followed by stray bytes,
// or one of the framing errors. A predictor in the bench tracks the decoder
// state and queues one expected result per accepted byte. A checker compares
// every result word, field by field, against the oldest expected result.
// ----------------------------------------------------------------------------
module http_chunked_body_decoder_core_tb;
  import hcbd_pkg::*;

  logic       clk_i       = 1'b0;
  logic       rst_ni      = 1'b0;
  logic       in_valid_i  = 1'b0;
  logic       in_ready_o;
  logic [7:0] in_byte_i   = 8'h00;
  logic       out_valid_o;
  logic       out_ready_i = 1'b0;
  logic       payload_valid_o;
  logic [7:0] payload_byte_o;
  logic       chunk_end_o;
  logic       body_done_o;
  logic [2:0] error_code_o;

  // Predicted decoder state.
  phase_e              dec_phase;
  logic [SizeBits-1:0] dec_remaining;
  logic                dec_digit;
  logic [1:0]          dec_match;
  err_e                dec_err;

  result_t expected_results[$];
  int      items_sent     = 0;
  int      fail_count     = 0;
  int      send_idle_pct  = 19;
  int      recv_idle_pct  = 68;

  http_chunked_body_decoder_core i_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .in_byte_i      (in_byte_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .payload_valid_o(payload_valid_o),
    .payload_byte_o (payload_byte_o),
    .chunk_end_o    (chunk_end_o),
    .body_done_o    (body_done_o),
    .error_code_o   (error_code_o)
  );

  always #2 clk_i = ~clk_i;

  // Value of a hex digit character, or -1 for any other byte.
  function automatic int hex_nibble(input logic [7:0] c);
    if (c inside {[8'h30:8'h39]}) return int'(c) - 48;
    if (c inside {[8'h41:8'h46]}) return int'(c) - 55;
    if (c inside {[8'h61:8'h66]}) return int'(c) - 87;
    return -1;
  endfunction

  // Advances the predicted state by one byte and returns the result word.
  function automatic result_t decode_step(input logic [7:0] b);
    result_t r;
    err_e    code;
    int      nib;
    r    = '0;
    code = ERR_NONE;
    if (dec_err != ERR_NONE) begin
      r.error_code = dec_err;
      return r;
    end
    case (dec_phase)
      PH_SIZE: begin
        nib = hex_nibble(b);
        if (nib >= 0) begin
          if (dec_remaining[SizeBits-1 -: 4] != 4'h0) begin
            code = ERR_OVERFLOW;
          end else begin
            dec_remaining = {dec_remaining[SizeBits-5:0], nib[3:0]};
            dec_digit     = 1'b1;
          end
        end else if (!dec_digit) begin
          code = ERR_NO_DIGIT;
        end else if (b == CharCr || b == CharSemi) begin
          // The size delimiter already counts toward the CRLF search.
          dec_match = (b == CharCr) ? MatchCr : MatchNone;
          dec_phase = (dec_remaining == '0) ? PH_TRAILER : PH_EXT;
        end else begin
          code = ERR_BAD_CHAR;
        end
      end
      PH_EXT: begin
        if (b == CharCr) begin
          dec_match = MatchCr;
        end else if (b == CharLf && dec_match == MatchCr) begin
          dec_match = MatchNone;
          dec_digit = 1'b0;
          dec_phase = PH_DATA;
        end else begin
          dec_match = MatchNone;
        end
      end
      PH_DATA: begin
        r.payload_valid = 1'b1;
        r.payload_byte  = b;
        dec_remaining   = dec_remaining - SizeBits'(1);
        if (dec_remaining == '0) begin
          r.chunk_end = 1'b1;
          dec_phase   = PH_DCR;
        end
      end
      PH_DCR: begin
        if (b == CharCr) dec_phase = PH_DLF;
        else code = ERR_NO_CRLF;
      end
      PH_DLF: begin
        if (b == CharLf) begin
          dec_phase     = PH_SIZE;
          dec_remaining = '0;
          dec_digit     = 1'b0;
        end else begin
          code = ERR_NO_CRLF;
        end
      end
      PH_TRAILER: begin
        if (b == CharCr) begin
          dec_match = (dec_match == MatchCrLf) ? MatchCrLfCr : MatchCr;
        end else if (b == CharLf && dec_match == MatchCr) begin
          dec_match = MatchCrLf;
        end else if (b == CharLf && dec_match == MatchCrLfCr) begin
          dec_match   = MatchNone;
          r.body_done = 1'b1;
          dec_phase   = PH_DONE;
        end else begin
          dec_match = MatchNone;
        end
      end
      default: code = ERR_AFTER_DONE;
    endcase
    // An error wipes the other fields and sticks until reset.
    if (code != ERR_NONE) begin
      dec_err      = code;
      r            = '0;
      r.error_code = code;
    end
    return r;
  endfunction

  // Random hex digit character for a nibble, in either letter case.
  function automatic logic [7:0] hex_char(input logic [3:0] nib);
    if (nib < 4'd10) return 8'h30 + 8'(nib);
    return ($urandom_range(1) ? 8'h61 : 8'h41) + 8'(nib - 4'd10);
  endfunction

  // Random byte that is no hex digit; optionally CR and ';' are excluded too.
  function automatic logic [7:0] random_nonhex(input bit no_delim);
    logic [7:0] c;
    do begin
      c = 8'($urandom_range(255));
    end while (hex_nibble(c) >= 0 || (no_delim && (c == CharCr || c == CharSemi)));
    return c;
  endfunction

  // Random byte other than LF, so that no CRLF forms by accident.
  function automatic logic [7:0] random_non_lf();
    logic [7:0] c;
    do c = 8'($urandom_range(255)); while (c == CharLf);
    return c;
  endfunction

  // Sends one word and records its expected result once it is accepted.
  task automatic send_byte(input logic [7:0] b);
    if (items_sent == 700) begin
      send_idle_pct = 68;
      recv_idle_pct = 19;
    end else if (items_sent == 1400) begin
      send_idle_pct = 0;
      recv_idle_pct = 0;
    end
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < send_idle_pct);
    end
    in_valid_i <= 1'b1;
    in_byte_i  <= b;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    expected_results.insert(expected_results.size(), decode_step(b));
    items_sent++;
  endtask

  // Hex size, sometimes with leading zeros.
  task automatic send_size(input int unsigned value);
    int n;
    n = 1;
    while (n < 8 && (value >> (4 * n)) != 0) n++;
    if ($urandom_range(3) == 0) repeat ($urandom_range(1, 3)) send_byte("0");
    for (int i = n - 1; i >= 0; i--) send_byte(hex_char(4'((value >> (4 * i)) & 'hF)));
  endtask

  // End of a size line: plain CRLF, an extension, or stray bytes after a CR.
  task automatic send_size_end();
    case ($urandom_range(4))
      0, 1, 2: ;
      3: begin
        send_byte(CharSemi);
        repeat ($urandom_range(6)) send_byte(random_non_lf());
      end
      default: begin
        send_byte(CharCr);
        repeat ($urandom_range(1, 3)) send_byte(random_non_lf());
      end
    endcase
    send_byte(CharCr);
    send_byte(CharLf);
  endtask

  // One complete chunk with random data.
  task automatic send_chunk(input int unsigned size);
    send_size(size);
    send_size_end();
    repeat (size) send_byte(8'($urandom_range(255)));
    send_byte(CharCr);
    send_byte(CharLf);
  endtask

  // Bytes after the body has ended or failed; each of them must come back with an error code.
  task automatic send_stray_bytes();
    repeat ($urandom_range(3, 8)) send_byte(8'($urandom_range(255)));
  endtask

  // Short chunks with a leading-zero size, an extension and framing bytes as data.
  task automatic test_directed_chunks();
    logic [7:0] data [11] = '{8'hFF, CharCr, CharLf, CharSemi, 8'h80, 8'h7F,
                              8'h01, 8'hFE, 8'h30, 8'h46, 8'h66};
    send_byte("0");
    send_byte("1");
    send_byte(CharSemi);
    send_byte("x");
    send_byte(CharCr);
    send_byte(CharLf);
    send_byte(8'h00);
    send_byte(CharCr);
    send_byte(CharLf);
    send_byte("B");
    send_byte(CharCr);
    send_byte(CharLf);
    foreach (data[i]) send_byte(data[i]);
    send_byte(CharCr);
    send_byte(CharLf);
  endtask

  // Well-formed chunks until the stream is long enough; mostly small sizes.
  task automatic test_random_chunks();
    while (items_sent < 1950) begin
      if ($urandom_range(9) == 0) send_chunk($urandom_range(41, 300));
      else send_chunk($urandom_range(1, 40));
    end
  endtask

  // Last chunk, trailer lines, the closing CRLFCRLF and then stray bytes.
  task automatic test_body_done();
    send_size(0);
    send_size_end();
    repeat ($urandom_range(2)) begin
      repeat ($urandom_range(1, 8)) begin
        logic [7:0] c;
        do c = 8'($urandom_range(255)); while (c == CharCr || c == CharLf);
        send_byte(c);
      end
      send_byte(CharCr);
      send_byte(CharLf);
    end
    send_byte(CharCr);
    send_byte(CharLf);
    send_stray_bytes();
  endtask

  // The data is not followed by CR, or the CR is not followed by LF.
  task automatic test_missing_crlf();
    int unsigned size;
    size = $urandom_range(1, 5);
    send_size(size);
    send_size_end();
    repeat (size) send_byte(8'($urandom_range(255)));
    if ($urandom_range(1)) begin
      send_byte(CharCr);
      send_byte(random_non_lf());
    end else begin
      logic [7:0] c;
      do c = 8'($urandom_range(255)); while (c == CharCr);
      send_byte(c);
    end
    send_stray_bytes();
  endtask

  // A size line that starts with something other than a hex digit.
  task automatic test_no_digit();
    send_byte(random_nonhex(1'b0));
    send_stray_bytes();
  endtask

  // A size that runs into a byte that is neither a digit nor a delimiter.
  task automatic test_bad_size_char();
    repeat ($urandom_range(1, 3)) send_byte(hex_char(4'($urandom_range(15))));
    send_byte(random_nonhex(1'b1));
    send_stray_bytes();
  endtask

  // A digit arrives once the top nibble of the size is in use.
  task automatic test_size_overflow();
    send_byte(hex_char(4'($urandom_range(1, 15))));
    repeat (SizeBits / 4 - 1) send_byte(hex_char(4'($urandom_range(15))));
    send_byte(hex_char(4'($urandom_range(15))));
    send_stray_bytes();
  endtask

  // Receiver: random stalls, and every result word checked in order.
  initial begin
    forever begin
      @(posedge clk_i);
      if (out_valid_o && out_ready_i) begin
        if (expected_results.size() == 0) begin
          fail_count++;
          if (fail_count <= 10) $display("Unexpected result word at %0t", $realtime);
        end else begin
          result_t exp;
          exp = expected_results.pop_front();
          if (payload_valid_o !== exp.payload_valid || payload_byte_o !== exp.payload_byte ||
              chunk_end_o !== exp.chunk_end || body_done_o !== exp.body_done ||
              error_code_o !== exp.error_code) begin
            fail_count++;
            if (fail_count <= 10) begin
              $write("Mismatch at %0t: exp pv=%0b pb=%02h ce=%0b bd=%0b err=%0d, ",
                     $realtime, exp.payload_valid, exp.payload_byte, exp.chunk_end,
                     exp.body_done, exp.error_code);
              $display("got pv=%0b pb=%02h ce=%0b bd=%0b err=%0d",
                       payload_valid_o, payload_byte_o, chunk_end_o, body_done_o,
                       error_code_o);
            end
          end
        end
      end
      out_ready_i <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Main sequence.
  initial begin
    dec_phase     = PH_SIZE;
    dec_remaining = '0;
    dec_digit     = 1'b0;
    dec_match     = MatchNone;
    dec_err       = ERR_NONE;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed_chunks();
    test_random_chunks();
    // Only one way of ending the body fits into a run with a single reset.
    case ($urandom_range(4))
      0: test_body_done();
      1: test_missing_crlf();
      2: test_no_digit();
      3: test_bad_size_char();
      default: test_size_overflow();
    endcase
    in_valid_i <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  // Watchdog.
  initial begin
    #2ms;
    $display("Verification failed");
    $finish;
  end

endmodule
